>>> hw/rtl/weather_sensor_pulse_distance_tx_defines.svh
// Assertion macros used by the checker file of the transmitter.
`ifndef WEATHER_SENSOR_PULSE_DISTANCE_TX_DEFINES_SVH
`define WEATHER_SENSOR_PULSE_DISTANCE_TX_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define WSPD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define WSPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/wspd_pkg.sv
package wspd_pkg;

   // Frame and field geometry.
   localparam int unsigned FRAME_BITS      = 36;
   localparam int unsigned POS_WIDTH       = 6;
   localparam int unsigned CFG_WIDTH       = 13;
   localparam int unsigned REPEAT_WIDTH    = 4;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned TEMP_WIDTH      = 12;

   // Default segment counter width.
   localparam int unsigned TIMER_WIDTH_DEFAULT = 13;

   // Register reset values.
   localparam logic [CFG_WIDTH-1:0]    HIGH_TICKS_RESET     = 13'd500;
   localparam logic [CFG_WIDTH-1:0]    SYNC_LOW_TICKS_RESET = 13'd4000;
   localparam logic [CFG_WIDTH-1:0]    ONE_LOW_TICKS_RESET  = 13'd2000;
   localparam logic [CFG_WIDTH-1:0]    ZERO_LOW_TICKS_RESET = 13'd1000;
   localparam logic [REPEAT_WIDTH-1:0] REPEAT_COUNT_RESET   = 4'd5;

   // Command codes of an input word.
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_HIGH_TICKS     = 3'd0,
      CSR_SYNC_LOW_TICKS = 3'd1,
      CSR_ONE_LOW_TICKS  = 3'd2,
      CSR_ZERO_LOW_TICKS = 3'd3,
      CSR_REPEAT_COUNT   = 3'd4
   } csr_index_type;

   // One result word.
   typedef struct packed {
      logic                  line_level;
      logic                  busy_res;
      logic                  start_rejected;
      logic [FRAME_BITS-1:0] frame_word;
      logic                  finished;
   } rsp_word_type;

   // Build the frame. A negative temperature goes out as the ones' complement
   // of its magnitude, which is the value minus one in 12 bits.
   function automatic logic [FRAME_BITS-1:0] pack_frame(
      input logic [7:0]                   sensor_id,
      input logic                         battery_flag,
      input logic [1:0]                   channel,
      input logic signed [TEMP_WIDTH-1:0] temperature,
      input logic [7:0]                   humidity
   );
      logic [TEMP_WIDTH-1:0] temp_code;
      temp_code = temperature[TEMP_WIDTH-1] ? (temperature - 1'b1) : temperature;
      return {sensor_id, battery_flag, 1'b0, channel, temp_code, 4'hF, humidity};
   endfunction

endpackage

>>> hw/rtl/weather_sensor_pulse_distance_tx.sv
// Pulse-distance OOK weather sensor transmitter. A start word packs a 36-bit
// frame (id, battery, channel, temperature, humidity) and begins sending it;
// each tick word moves the waveform one time unit: a sync pulse and long low
// gap, then 36 bits, each a high pulse followed by a long (one) or short (zero)
// low gap, repeated repeat_count times. Every input word yields one result
// word. The block takes one word per clock cycle unless a stalled result holds
// it, and registers its result; the rate is set by the single state update
// between the input handshake and the result register. A start while busy is
// rejected and leaves the transmission untouched. Configuration writes are
// taken in any cycle and apply at the next segment load.
module weather_sensor_pulse_distance_tx
   import wspd_pkg::*;
#(
   parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // Input words
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_command,
   input  logic [7:0]                  req_sensor_id,
   input  logic                        req_battery_flag,
   input  logic [1:0]                  req_channel,
   input  logic signed [TEMP_WIDTH-1:0] req_temperature_tenths,
   input  logic [7:0]                  req_humidity,
   // Result words
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_line_level,
   output logic                        rsp_busy_res,
   output logic                        rsp_start_rejected,
   output logic [FRAME_BITS-1:0]       rsp_frame_word,
   output logic                        rsp_finished,
   // Configuration writes
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [CFG_WIDTH-1:0]        csr_data
);

   // Configuration registers.
   logic [CFG_WIDTH-1:0]    high_ticks_ff, sync_low_ticks_ff;
   logic [CFG_WIDTH-1:0]    one_low_ticks_ff, zero_low_ticks_ff;
   logic [REPEAT_WIDTH-1:0] repeat_count_ff;

   // Transmit state.
   logic [FRAME_BITS-1:0]   frame_store_ff, frame_store_in;
   logic [REPEAT_WIDTH-1:0] repeats_left_ff, repeats_left_in;
   logic [POS_WIDTH-1:0]    bit_position_ff, bit_position_in;
   logic                    in_high_phase_ff, in_high_phase_in;
   logic [TIMER_WIDTH-1:0]  tick_countdown_ff, tick_countdown_in;
   logic                    active_ff, active_in;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_word_type            rsp_word_ff, rsp_word_in;

   logic                    req_fire;
   logic                    rejected;
   logic                    done;
   logic [TIMER_WIDTH-1:0]  countdown_dec;
   logic [POS_WIDTH-1:0]    position_inc;
   logic [POS_WIDTH-1:0]    frame_bit_idx;
   logic                    frame_bit;
   logic [TIMER_WIDTH-1:0]  low_len;

   // A segment length is cut to the counter width, and zero counts as one tick.
   function automatic logic [TIMER_WIDTH-1:0] seg_len(input logic [CFG_WIDTH-1:0] v);
      logic [TIMER_WIDTH-1:0] t;
      t = TIMER_WIDTH'(v);
      return (t == '0) ? TIMER_WIDTH'(1) : t;
   endfunction

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         high_ticks_ff     <= HIGH_TICKS_RESET;
         sync_low_ticks_ff <= SYNC_LOW_TICKS_RESET;
         one_low_ticks_ff  <= ONE_LOW_TICKS_RESET;
         zero_low_ticks_ff <= ZERO_LOW_TICKS_RESET;
         repeat_count_ff   <= REPEAT_COUNT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_HIGH_TICKS:     high_ticks_ff     <= csr_data;
            CSR_SYNC_LOW_TICKS: sync_low_ticks_ff <= csr_data;
            CSR_ONE_LOW_TICKS:  one_low_ticks_ff  <= csr_data;
            CSR_ZERO_LOW_TICKS: zero_low_ticks_ff <= csr_data;
            CSR_REPEAT_COUNT:   repeat_count_ff   <= csr_data[REPEAT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Low gap after the current high pulse: sync gap at position zero, else
   // chosen by the frame bit that this position sends.
   assign countdown_dec = tick_countdown_ff - 1'b1;
   assign position_inc  = bit_position_ff + 1'b1;
   assign frame_bit_idx = POS_WIDTH'(FRAME_BITS) - bit_position_ff;
   assign frame_bit     = frame_store_ff[frame_bit_idx];

   always_comb begin
      if (bit_position_ff == '0) begin
         low_len = seg_len(sync_low_ticks_ff);
      end else if (frame_bit) begin
         low_len = seg_len(one_low_ticks_ff);
      end else begin
         low_len = seg_len(zero_low_ticks_ff);
      end
   end

   // Next state for the accepted word.
   always_comb begin
      frame_store_in    = frame_store_ff;
      repeats_left_in   = repeats_left_ff;
      bit_position_in   = bit_position_ff;
      in_high_phase_in  = in_high_phase_ff;
      tick_countdown_in = tick_countdown_ff;
      active_in         = active_ff;
      rejected          = 1'b0;
      done              = 1'b0;
      if (req_fire) begin
         if (req_command == CMD_START) begin
            if (active_ff) begin
               rejected = 1'b1;
            end else begin
               frame_store_in    = pack_frame(req_sensor_id, req_battery_flag, req_channel,
                                              req_temperature_tenths, req_humidity);
               repeats_left_in   = (repeat_count_ff == '0) ? REPEAT_WIDTH'(1)
                                                           : repeat_count_ff;
               bit_position_in   = '0;
               in_high_phase_in  = 1'b1;
               tick_countdown_in = seg_len(high_ticks_ff);
               active_in         = 1'b1;
            end
         end else if (active_ff) begin
            tick_countdown_in = countdown_dec;
            if (countdown_dec == '0) begin
               if (in_high_phase_ff) begin
                  in_high_phase_in  = 1'b0;
                  tick_countdown_in = low_len;
               end else begin
                  bit_position_in   = position_inc;
                  in_high_phase_in  = 1'b1;
                  tick_countdown_in = seg_len(high_ticks_ff);
                  // Past the last frame bit: one repetition is complete.
                  if (position_inc > POS_WIDTH'(FRAME_BITS)) begin
                     bit_position_in = '0;
                     repeats_left_in = repeats_left_ff - 1'b1;
                     if (repeats_left_ff == REPEAT_WIDTH'(1)) begin
                        active_in         = 1'b0;
                        in_high_phase_in  = 1'b0;
                        tick_countdown_in = '0;
                        done              = 1'b1;
                     end
                  end
               end
            end
         end
      end
   end

   // Result word and output valid.
   always_comb begin
      rsp_word_in.line_level     = active_in && in_high_phase_in;
      rsp_word_in.busy_res       = active_in;
      rsp_word_in.start_rejected = rejected;
      rsp_word_in.frame_word     = frame_store_in;
      rsp_word_in.finished       = done;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State and valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_store_ff    <= '0;
         repeats_left_ff   <= '0;
         bit_position_ff   <= '0;
         in_high_phase_ff  <= 1'b0;
         tick_countdown_ff <= '0;
         active_ff         <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         frame_store_ff    <= frame_store_in;
         repeats_left_ff   <= repeats_left_in;
         bit_position_ff   <= bit_position_in;
         in_high_phase_ff  <= in_high_phase_in;
         tick_countdown_ff <= tick_countdown_in;
         active_ff         <= active_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Result payload is loaded only when a word is accepted.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_line_level     = rsp_word_ff.line_level;
   assign rsp_busy_res       = rsp_word_ff.busy_res;
   assign rsp_start_rejected = rsp_word_ff.start_rejected;
   assign rsp_frame_word     = rsp_word_ff.frame_word;
   assign rsp_finished       = rsp_word_ff.finished;

endmodule

>>> hw/rtl/wspd_checker.sv
`include "weather_sensor_pulse_distance_tx_defines.svh"

module wspd_checker
   import wspd_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_line_level,
   input logic                        rsp_busy_res,
   input logic                        rsp_start_rejected,
   input logic [FRAME_BITS-1:0]       rsp_frame_word,
   input logic                        rsp_finished
);

   // A stalled result word holds.
   `WSPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_frame_word) && $stable(rsp_line_level),
      "stalled result word changed")

   // The line is only high while a frame is being sent.
   `WSPD_ASSERT_NOW(a_line_busy, clock, reset, rsp_valid && rsp_line_level, rsp_busy_res,
      "line high while idle")

   // The word that ends the last repetition leaves the block idle and low.
   `WSPD_ASSERT_NOW(a_finish_idle, clock, reset, rsp_valid && rsp_finished,
      !rsp_busy_res && !rsp_line_level && !rsp_start_rejected, "finish word not idle")

   // A start is only rejected during a transmission.
   `WSPD_ASSERT_NOW(a_reject_busy, clock, reset, rsp_valid && rsp_start_rejected,
      rsp_busy_res, "start rejected while idle")

   // A frame being sent carries its fixed marker bits.
   `WSPD_ASSERT_NOW(a_frame_marks, clock, reset, rsp_valid && rsp_busy_res,
      (rsp_frame_word[11:8] == 4'hF) && !rsp_frame_word[26], "frame marker bits wrong")

endmodule

bind weather_sensor_pulse_distance_tx wspd_checker u_wspd_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_valid),
   .rsp_ready              (rsp_ready),
   .rsp_line_level         (rsp_line_level),
   .rsp_busy_res           (rsp_busy_res),
   .rsp_start_rejected     (rsp_start_rejected),
   .rsp_frame_word         (rsp_frame_word),
   .rsp_finished           (rsp_finished)
);

>>> dv/weather_sensor_pulse_distance_tx_test.sv
`timescale 1ns / 100ps

module weather_sensor_pulse_distance_tx_test;
   import wspd_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 500_000;
   localparam int unsigned RANDOM_WORDS = 400;
   localparam int unsigned REPORT_LINES = 40;
   localparam logic [CFG_WIDTH-1:0] LENGTH_MAX  = '1;
   localparam logic [CFG_WIDTH-1:0] LONG_LENGTH = 13'd48;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_UNUSED = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAST_UNUSED  = 3'd7;

   // Clock, reset and the ports of the block.
   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_command = CMD_TICK;
   logic [7:0]                   req_sensor_id = '0;
   logic                         req_battery_flag = 1'b0;
   logic [1:0]                   req_channel = '0;
   logic signed [TEMP_WIDTH-1:0] req_temperature_tenths = '0;
   logic [7:0]                   req_humidity = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic                         rsp_line_level;
   logic                         rsp_busy_res;
   logic                         rsp_start_rejected;
   logic [FRAME_BITS-1:0]        rsp_frame_word;
   logic                         rsp_finished;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]   csr_index = '0;
   logic [CFG_WIDTH-1:0]         csr_data = '0;

   // Timing registers as the transmitter should hold them.
   logic [CFG_WIDTH-1:0]    cfg_high_ticks   = HIGH_TICKS_RESET;
   logic [CFG_WIDTH-1:0]    cfg_sync_ticks   = SYNC_LOW_TICKS_RESET;
   logic [CFG_WIDTH-1:0]    cfg_one_ticks    = ONE_LOW_TICKS_RESET;
   logic [CFG_WIDTH-1:0]    cfg_zero_ticks   = ZERO_LOW_TICKS_RESET;
   logic [REPEAT_WIDTH-1:0] cfg_repeat_count = REPEAT_COUNT_RESET;

   // Waveform state as the transmitter should hold it.
   logic [FRAME_BITS-1:0]          tx_frame   = '0;
   logic [REPEAT_WIDTH-1:0]        tx_repeats = '0;
   logic [POS_WIDTH-1:0]           tx_pos     = '0;
   logic                           tx_high    = 1'b0;
   logic [TIMER_WIDTH_DEFAULT-1:0] tx_count   = '0;
   logic                           tx_active  = 1'b0;

   // Line states expected from the result channel, oldest first.
   rsp_word_type line_state_queue[$];
   rsp_word_type got_word;
   rsp_word_type want_word;

   bit          idle_on = 1'b1;
   int unsigned stall_left = 0;
   int unsigned cycle_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned words_checked = 0;
   int unsigned frames_started = 0;
   int unsigned frames_finished = 0;
   int unsigned starts_refused = 0;
   int unsigned settings_applied = 0;

   weather_sensor_pulse_distance_tx u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_command            (req_command),
      .req_sensor_id          (req_sensor_id),
      .req_battery_flag       (req_battery_flag),
      .req_channel            (req_channel),
      .req_temperature_tenths (req_temperature_tenths),
      .req_humidity           (req_humidity),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_line_level         (rsp_line_level),
      .rsp_busy_res           (rsp_busy_res),
      .rsp_start_rejected     (rsp_start_rejected),
      .rsp_frame_word         (rsp_frame_word),
      .rsp_finished           (rsp_finished),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   // The clock runs at 50 MHz.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The run is cut off if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with results outstanding.", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // The result side stalls in random bursts while idling is on.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 17);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Print one line per mismatch, up to a cap, and count every one.
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < REPORT_LINES) begin
         $display("MISMATCH %s: got %0h, expected %0h (cycle %0d)",
                  what, got, want, cycle_count);
      end
      mismatch_count++;
   endtask

   // Every accepted result word is compared with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_word = {rsp_line_level, rsp_busy_res, rsp_start_rejected,
                     rsp_frame_word, rsp_finished};
         if (line_state_queue.size() == 0) begin
            report_mismatch("result word with nothing expected", 64'(got_word), '0);
         end else begin
            want_word = line_state_queue.pop_front();
            if (got_word.line_level !== want_word.line_level)
               report_mismatch("line_level", 64'(got_word.line_level),
                               64'(want_word.line_level));
            if (got_word.busy_res !== want_word.busy_res)
               report_mismatch("busy_res", 64'(got_word.busy_res),
                               64'(want_word.busy_res));
            if (got_word.start_rejected !== want_word.start_rejected)
               report_mismatch("start_rejected", 64'(got_word.start_rejected),
                               64'(want_word.start_rejected));
            if (got_word.frame_word !== want_word.frame_word)
               report_mismatch("frame_word", 64'(got_word.frame_word),
                               64'(want_word.frame_word));
            if (got_word.finished !== want_word.finished)
               report_mismatch("finished", 64'(got_word.finished),
                               64'(want_word.finished));
         end
         words_checked++;
      end
   end

   // A loaded segment length of zero lasts one tick.
   function automatic logic [TIMER_WIDTH_DEFAULT-1:0] segment_ticks(
      input logic [CFG_WIDTH-1:0] len
   );
      logic [TIMER_WIDTH_DEFAULT-1:0] masked;
      masked = len;
      return (masked == '0) ? TIMER_WIDTH_DEFAULT'(1) : masked;
   endfunction

   // Advance the expected waveform by one input word and return the line state.
   function automatic rsp_word_type predict_line_state(
      input logic cmd, input logic [7:0] id, input logic batt,
      input logic [1:0] ch, input logic [TEMP_WIDTH-1:0] temp, input logic [7:0] hum
   );
      rsp_word_type          state;
      logic [TEMP_WIDTH-1:0] temp_code;
      state = '0;
      if (cmd == CMD_START) begin
         if (tx_active) begin
            state.start_rejected = 1'b1;
         end else begin
            // Below zero the magnitude goes out inverted, i.e. the value less one.
            temp_code  = temp[TEMP_WIDTH-1] ? TEMP_WIDTH'(temp - 1) : temp;
            tx_frame   = {id, batt, 1'b0, ch, temp_code, 4'hF, hum};
            tx_repeats = (cfg_repeat_count == '0) ? REPEAT_WIDTH'(1) : cfg_repeat_count;
            tx_pos     = '0;
            tx_high    = 1'b1;
            tx_count   = segment_ticks(cfg_high_ticks);
            tx_active  = 1'b1;
         end
      end else if (tx_active) begin
         tx_count = tx_count - 1'b1;
         if (tx_count == '0) begin
            if (tx_high) begin
               // The low gap after the sync pulse or after one frame bit.
               tx_high = 1'b0;
               if (tx_pos == '0)
                  tx_count = segment_ticks(cfg_sync_ticks);
               else if (tx_frame[FRAME_BITS - tx_pos])
                  tx_count = segment_ticks(cfg_one_ticks);
               else
                  tx_count = segment_ticks(cfg_zero_ticks);
            end else begin
               tx_pos   = tx_pos + 1'b1;
               tx_high  = 1'b1;
               tx_count = segment_ticks(cfg_high_ticks);
               // Past the last bit the repetition ends.
               if (tx_pos > FRAME_BITS) begin
                  tx_pos     = '0;
                  tx_repeats = tx_repeats - 1'b1;
                  if (tx_repeats == '0) begin
                     tx_active      = 1'b0;
                     tx_high        = 1'b0;
                     tx_count       = '0;
                     state.finished = 1'b1;
                  end
               end
            end
         end
      end
      state.line_level = tx_active && tx_high;
      state.busy_res   = tx_active;
      state.frame_word = tx_frame;
      return state;
   endfunction

   // Offer one input word, wait until it is taken and record its expected result.
   task automatic send_word(input logic cmd, input logic [7:0] id, input logic batt,
                            input logic [1:0] ch, input logic [TEMP_WIDTH-1:0] temp,
                            input logic [7:0] hum);
      rsp_word_type want;
      if (idle_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_command            <= cmd;
      req_sensor_id          <= id;
      req_battery_flag       <= batt;
      req_channel            <= ch;
      req_temperature_tenths <= temp;
      req_humidity           <= hum;
      do @(posedge clock); while (!req_ready);
      want = predict_line_state(cmd, id, batt, ch, temp, hum);
      line_state_queue.push_back(want);
      if (cmd == CMD_START) begin
         if (want.start_rejected) starts_refused++;
         else frames_started++;
      end
      if (want.finished) frames_finished++;
   endtask

   // A tick carries random data in the fields it does not use.
   task automatic send_tick();
      send_word(CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                2'($urandom_range(0, 3)), TEMP_WIDTH'($urandom_range(0, 4095)),
                8'($urandom_range(0, 255)));
   endtask

   task automatic send_random_start();
      send_word(CMD_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                2'($urandom_range(0, 3)), TEMP_WIDTH'($urandom_range(0, 4095)),
                8'($urandom_range(0, 255)));
   endtask

   // Stop offering words and wait until every expected result has come back.
   task automatic settle_line();
      req_valid <= 1'b0;
      while (line_state_queue.size() != 0) @(posedge clock);
   endtask

   // One register write; valid stays high so writes can follow back to back.
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CFG_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_HIGH_TICKS:     cfg_high_ticks   = data;
         CSR_SYNC_LOW_TICKS: cfg_sync_ticks   = data;
         CSR_ONE_LOW_TICKS:  cfg_one_ticks    = data;
         CSR_ZERO_LOW_TICKS: cfg_zero_ticks   = data;
         CSR_REPEAT_COUNT:   cfg_repeat_count = data[REPEAT_WIDTH-1:0];
         default: ;
      endcase
   endtask

   // Load all five timing registers once the result channel has drained.
   task automatic apply_timing(input logic [CFG_WIDTH-1:0] high_len,
                               input logic [CFG_WIDTH-1:0] sync_len,
                               input logic [CFG_WIDTH-1:0] one_len,
                               input logic [CFG_WIDTH-1:0] zero_len,
                               input logic [REPEAT_WIDTH-1:0] reps);
      settle_line();
      write_reg(CSR_HIGH_TICKS, high_len);
      write_reg(CSR_SYNC_LOW_TICKS, sync_len);
      write_reg(CSR_ONE_LOW_TICKS, one_len);
      write_reg(CSR_ZERO_LOW_TICKS, zero_len);
      write_reg(CSR_REPEAT_COUNT, CFG_WIDTH'(reps));
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // Reset high length and repeat count: idle ticks, extreme fields, a refused
   // start, and new settings written mid-pulse that only apply from the next
   // segment.
   task automatic test_default_timing();
      send_tick();
      send_tick();
      send_word(CMD_START, 8'hFF, 1'b1, 2'd3, 12'h7FF, 8'hFF);
      send_word(CMD_START, 8'h00, 1'b0, 2'd0, 12'h800, 8'h00);
      repeat (3) send_tick();
      apply_timing(13'd1, 13'd0, 13'd2, 13'd0, 4'd0);
      while (tx_active) send_tick();
      send_tick();
   endtask

   // Writes to the unused indexes must leave the timing alone.
   task automatic test_unused_registers();
      settle_line();
      for (int idx = CSR_FIRST_UNUSED; idx <= CSR_LAST_UNUSED; idx++)
         write_reg(CSR_INDEX_WIDTH'(idx), (idx == CSR_FIRST_UNUSED) ? LENGTH_MAX
                                          : CFG_WIDTH'($urandom_range(0, 8191)));
      csr_valid <= 1'b0;
      send_random_start();
      while (tx_active) send_tick();
   endtask

   // Frame packing across the temperature corners, with a refused start mid-frame.
   task automatic test_frame_layout();
      logic [7:0]            ids [5];
      logic [TEMP_WIDTH-1:0] temps [5];
      logic [7:0]            hums [5];
      int unsigned           n;
      ids   = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h3C};
      temps = '{12'h000, 12'hFFF, 12'h800, 12'h001, 12'hFFE};
      hums  = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'd100};
      apply_timing(13'd1, 13'd3, 13'd2, 13'd0, 4'd1);
      for (int i = 0; i < 5; i++) begin
         send_word(CMD_START, ids[i], i[0], i[1:0], temps[i], hums[i]);
         n = 0;
         while (tx_active) begin
            if (n == 7) send_random_start();
            else send_tick();
            n++;
         end
      end
      send_tick();
   endtask

   // Long segments: high and sync first, then a one gap and a zero gap,
   // each written while the frame runs; then a second short repetition.
   task automatic test_long_segments();
      apply_timing(LONG_LENGTH, LONG_LENGTH, 13'd1, 13'd1, 4'd2);
      send_word(CMD_START, 8'h80, 1'b0, 2'd1, 12'h123, 8'h42);
      while (tx_high) send_tick();
      apply_timing(13'd0, 13'd0, LONG_LENGTH, 13'd1, 4'd2);
      while (tx_pos < 2) send_tick();
      apply_timing(13'd0, 13'd0, 13'd0, LONG_LENGTH, 4'd2);
      while (tx_pos < 3) send_tick();
      apply_timing(13'd1, 13'd1, 13'd2, 13'd0, 4'd2);
      while (tx_active) send_tick();
   endtask

   // Segment length for random settings: mostly very short, now and then longer.
   function automatic logic [CFG_WIDTH-1:0] pick_length();
      return CFG_WIDTH'(($urandom_range(0, 15) == 0) ? $urandom_range(4, 12)
                                                     : $urandom_range(0, 3));
   endfunction

   // Random frames under random settings, with stray idle ticks and refused starts.
   task automatic test_random_traffic();
      int unsigned sent;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         idle_on = (sent < RANDOM_WORDS * 4 / 5) && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 2) == 0) begin
            apply_timing(pick_length(), pick_length(), pick_length(), pick_length(),
                         REPEAT_WIDTH'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                                  : $urandom_range(0, 3)));
         end
         repeat ($urandom_range(0, 2)) begin
            send_tick();
            sent++;
         end
         send_random_start();
         sent++;
         while (tx_active) begin
            if ($urandom_range(0, 24) == 0) send_random_start();
            else send_tick();
            sent++;
         end
      end
      idle_on = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_default_timing();
      test_unused_registers();
      test_frame_layout();
      test_long_segments();
      test_random_traffic();
      settle_line();
      repeat (4) @(posedge clock);
      $display("Checked %0d result words: %0d frames sent, %0d finished, %0d starts refused.",
               words_checked, frames_started, frames_finished, starts_refused);
      $display("Timing was reloaded %0d times, from zero lengths up to long segments.",
               settings_applied);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
